[rtl/core/nmea_sentence_header_checksum_assert.svh]
// assertion macros for the sentence header and checksum rtl, used by the sentence queue
`ifndef NMEA_SENTENCE_HEADER_CHECKSUM_ASSERT_SVH
`define NMEA_SENTENCE_HEADER_CHECKSUM_ASSERT_SVH

// concurrent check sampled on the rising clock, off while reset is high
`define NMEA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also holds through reset
`define NMEA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/nmea_pkg.sv]
// types, constants and id lookup functions for the sentence header and checksum block
package nmea_pkg;

   // framing characters
   localparam logic [7:0] StartChar = 8'h24;
   localparam logic [7:0] EndChar   = 8'h2A;

   // header layout: two talker bytes then three message bytes
   localparam int unsigned HdrLen    = 5;
   localparam int unsigned TalkLen   = 2;
   localparam int unsigned MsgLen    = 3;
   localparam int unsigned TalkCount = 5;
   localparam int unsigned MsgCount  = 18;
   localparam int unsigned PosWidth  = $clog2(HdrLen + 1);

   // default depth of the queue between front and back
   localparam int unsigned QueueDepthDefault = 4;

   localparam logic [8*TalkLen-1:0] TalkTab [TalkCount] = '{
      "GP", "GL", "GA", "GB", "GN"
   };

   localparam logic [8*MsgLen-1:0] MsgTab [MsgCount] = '{
      "DTM", "GBQ", "GBS", "GGA", "GLL", "GLQ", "GNQ", "GNS", "GPQ",
      "GRS", "GSA", "GST", "GSV", "RMC", "TXT", "VLW", "VTG", "ZDA"
   };

   // one closed sentence waiting for lookup
   typedef struct packed {
      logic [HdrLen-1:0][7:0] header;
      logic [7:0]             sum;
   } nmea_entry_type;

   // queue fill status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } nmea_q_status_type;

   // talker id match, 0 when nothing matches
   function automatic logic [2:0] talker_lookup(input logic [8*TalkLen-1:0] id);
      logic [2:0] code;
      code = '0;
      for (int k = TalkCount - 1; k >= 0; k--) begin
         if (id == TalkTab[k]) begin
            code = 3'(k + 1);
         end
      end
      return code;
   endfunction

   // message id match, 0 when nothing matches
   function automatic logic [4:0] message_lookup(input logic [8*MsgLen-1:0] id);
      logic [4:0] code;
      code = '0;
      for (int k = MsgCount - 1; k >= 0; k--) begin
         if (id == MsgTab[k]) begin
            code = 5'(k + 1);
         end
      end
      return code;
   endfunction

endpackage

[rtl/core/nmea_req_if.sv]
// input byte channel
interface nmea_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

[rtl/core/nmea_rsp_if.sv]
// sentence result channel
interface nmea_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] talker_code;
   logic [4:0] message_code;
   logic [7:0] sum_value;

   modport source (output valid, output talker_code, output message_code,
                   output sum_value, input ready);
   modport sink   (input valid, input talker_code, input message_code,
                   input sum_value, output ready);
endinterface

[rtl/core/nmea_front.sv]
// front end: byte framing, header capture and running checksum
module nmea_front (
   input  logic                        clock,
   input  logic                        reset,
   nmea_req_if.sink                    req,
   input  nmea_pkg::nmea_q_status_type q_status,
   output logic                        push,
   output nmea_pkg::nmea_entry_type    push_data
);
   import nmea_pkg::*;

   logic                   in_sentence_ff, in_sentence_in;
   logic [PosWidth-1:0]    position_ff, position_in;
   logic [HdrLen-1:0][7:0] header_ff, header_in;
   logic [7:0]             sum_ff, sum_in;
   logic                   take;

   // accept bytes whenever the queue has room
   assign req.ready = !q_status.full;
   assign take      = req.valid && req.ready;

   // a closing star inside a sentence hands the header and sum to the queue
   assign push             = take && in_sentence_ff && (req.data_byte == EndChar);
   assign push_data.header = header_ff;
   assign push_data.sum    = sum_ff;

   // sentence state update
   always_comb begin
      in_sentence_in = in_sentence_ff;
      position_in    = position_ff;
      header_in      = header_ff;
      sum_in         = sum_ff;
      if (take) begin
         if (req.data_byte == StartChar) begin
            in_sentence_in = 1'b1;
            position_in    = '0;
            header_in      = '0;
            sum_in         = '0;
         end else if (in_sentence_ff) begin
            if (req.data_byte == EndChar) begin
               in_sentence_in = 1'b0;
            end else begin
               sum_in = sum_ff ^ req.data_byte;
               if (position_ff < PosWidth'(HdrLen)) begin
                  for (int i = 0; i < HdrLen; i++) begin
                     if (position_ff == PosWidth'(i)) begin
                        header_in[i] = req.data_byte;
                     end
                  end
                  position_in = position_ff + 1'b1;
               end
            end
         end
      end
   end

   // control state resets, header and sum are cleared by the start character
   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         position_ff    <= '0;
      end else begin
         in_sentence_ff <= in_sentence_in;
         position_ff    <= position_in;
      end
      header_ff <= header_in;
      sum_ff    <= sum_in;
   end

endmodule

[rtl/core/nmea_fifo.sv]
// short queue of closed sentences between front and back
`include "nmea_sentence_header_checksum_assert.svh"

module nmea_fifo #(
   parameter int unsigned Depth = nmea_pkg::QueueDepthDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  nmea_pkg::nmea_entry_type    push_data,
   input  logic                        pop,
   output nmea_pkg::nmea_entry_type    pop_data,
   output nmea_pkg::nmea_q_status_type status
);
   import nmea_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);

   nmea_entry_type      slot_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CntWidth'(Depth));
   assign status.empty = (count_ff == '0);
   assign pop_data     = slot_ff[rd_ptr_ff];

   // pointer wrap and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `NMEA_ASSERT(a_no_push_full, clock, reset, push |-> !status.full, "push into full queue")
   `NMEA_ASSERT(a_no_pop_empty, clock, reset, pop |-> !status.empty, "pop from empty queue")
   `NMEA_ASSERT(a_count_up, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "count missed a push")
   `NMEA_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CntWidth'(Depth)), "count beyond depth")

endmodule

[rtl/core/nmea_back.sv]
// back end: talker and message lookup into the output register
module nmea_back (
   input  logic                        clock,
   input  logic                        reset,
   input  nmea_pkg::nmea_q_status_type q_status,
   input  nmea_pkg::nmea_entry_type    pop_data,
   output logic                        pop,
   nmea_rsp_if.source                  rsp
);
   import nmea_pkg::*;

   logic       valid_ff, valid_in;
   logic [2:0] talker_ff, talker_in;
   logic [4:0] message_ff, message_in;
   logic [7:0] sum_ff;
   logic       load;

   // refill the output register when it is empty or being drained
   assign load = !valid_ff || rsp.ready;
   assign pop  = load && !q_status.empty;

   // id classification of the queue head
   assign talker_in  = talker_lookup({pop_data.header[0], pop_data.header[1]});
   assign message_in = message_lookup({pop_data.header[2], pop_data.header[3],
                                       pop_data.header[4]});
   assign valid_in   = load ? !q_status.empty : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (pop) begin
         talker_ff  <= talker_in;
         message_ff <= message_in;
         sum_ff     <= pop_data.sum;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.talker_code  = talker_ff;
   assign rsp.message_code = message_ff;
   assign rsp.sum_value    = sum_ff;

endmodule

[rtl/core/nmea_sentence_header_checksum.sv]
// nmea sentence header and checksum: one byte per cycle in while the queue has room, one result per closed sentence
// throughput: one byte accepted per cycle while the sentence queue has room
// a result passes through the sentence queue and then the output register after its closing star transfers
// the queue holds QueueDepth closed sentences; bytes stall only when it is full
// reset (synchronous, active high) leaves the block outside a sentence with the queue empty
module nmea_sentence_header_checksum #(
   parameter int unsigned QueueDepth = nmea_pkg::QueueDepthDefault
) (
   input  logic         clock,
   input  logic         reset,
   nmea_req_if.sink     req_bus,
   nmea_rsp_if.source   rsp_bus
);
   import nmea_pkg::*;

   nmea_q_status_type q_status;
   nmea_entry_type    push_data;
   nmea_entry_type    pop_data;
   logic              push;
   logic              pop;

   // framing and checksum
   nmea_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // closed sentence queue
   nmea_fifo #(
      .Depth (QueueDepth)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // id lookup and result register
   nmea_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp      (rsp_bus)
   );

endmodule
